// File: src/assert_macros.svh
// Assertion macros shared by the RTL files of the I2C transfer sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant violated");

// A consequent that must hold in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication violated");

// A consequent that must hold in the cycle after its antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// File: src/i2cms_pkg.sv
// Types, codes and constants shared by the I2C transfer sequencer modules.
`default_nettype none

package i2cms_pkg;

  localparam int unsigned DEF_MAX_MSGS = 255;
  localparam int unsigned MSG_CNT_W    = 8;
  localparam int unsigned MSG_CNT_MAX  = (1 << MSG_CNT_W) - 1;

  localparam logic [7:0] ADDR10_PREFIX  = 8'hF0;
  localparam logic [7:0] ADDR10_HI_MASK = 8'h06;
  localparam logic [7:0] ADDR7_LO_MASK  = 8'hFF;
  localparam logic [7:0] READ_BIT       = 8'h01;

  typedef enum logic [1:0] {
    REQ_HEADER = 2'd0,
    REQ_DATA   = 2'd1,
    REQ_END    = 2'd2
  } req_type_t;

  typedef enum logic [2:0] {
    OP_START   = 3'd0,
    OP_RESTART = 3'd1,
    OP_STOP    = 3'd2,
    OP_SEND    = 3'd3,
    OP_RECV    = 3'd4,
    OP_ACK     = 3'd5,
    OP_NACK    = 3'd6,
    OP_STATUS  = 3'd7
  } bus_op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DATA_NACK = 2'd1,
    ST_ADDR_NACK = 2'd2
  } status_t;

  // Fixed result slots; an item enables the subset it needs, in this order.
  localparam int unsigned NUM_SLOTS     = 13;
  localparam int unsigned SL_HEAD       = 0;
  localparam int unsigned SL_BYTE       = 1;
  localparam int unsigned SL_AUX        = 2;
  localparam int unsigned SL_RTY1_START = 3;
  localparam int unsigned SL_RTY1_SEND  = 4;
  localparam int unsigned SL_ADDR_LO    = 5;
  localparam int unsigned SL_RESTART    = 6;
  localparam int unsigned SL_ADDR_RD    = 7;
  localparam int unsigned SL_RTY2_STOP  = 8;
  localparam int unsigned SL_RTY2_START = 9;
  localparam int unsigned SL_RTY2_SEND  = 10;
  localparam int unsigned SL_STOP       = 11;
  localparam int unsigned SL_STATUS     = 12;

  typedef struct packed {
    req_type_t   req_type;
    logic [9:0]  dev_addr;
    logic        ten_bit;
    logic        is_read;
    logic        tolerate_nack;
    logic        skip_start;
    logic        no_master_ack;
    logic [7:0]  wr_byte;
    logic [7:0]  rd_byte;
    logic [4:0]  ack_bits;
    logic        last_byte;
  } req_t;

  typedef struct packed {
    logic                 in_transfer;
    logic                 aborted;
    logic [MSG_CNT_W-1:0] msgs_done;
    logic                 cur_read;
    logic                 cur_tolerate_nack;
    logic                 cur_no_master_ack;
    logic                 msg_open;
  } seq_state_t;

  typedef struct packed {
    bus_op_t    op;
    logic [7:0] byte_val;
  } slot_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0]  en;
    slot_t [NUM_SLOTS-1:0] slots;
    status_t               status;
    logic [MSG_CNT_W-1:0]  msg_count;
  } plan_t;

  function automatic logic [MSG_CNT_W-1:0] msg_cap(input int unsigned max_msgs);
    logic [MSG_CNT_W-1:0] cap;
    cap = (max_msgs > MSG_CNT_MAX) ? MSG_CNT_W'(MSG_CNT_MAX) : MSG_CNT_W'(max_msgs);
    return cap;
  endfunction

endpackage

`default_nettype wire

// File: src/i2cms_out_buf.sv
// Result buffer that holds one item's bus symbols and hands them out one per transaction.
`default_nettype none
`include "assert_macros.svh"

module i2cms_out_buf
  import i2cms_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load,
  input  wire plan_t                plan,
  output logic                      free,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [2:0]                out_bus_op,
  output logic [7:0]                out_byte_val,
  output logic [1:0]                out_status,
  output logic [MSG_CNT_W-1:0]      out_msg_count,
  output logic                      out_last
);

  logic [NUM_SLOTS-1:0]  en_r;
  slot_t [NUM_SLOTS-1:0] slots_r;
  status_t               status_r;
  logic [MSG_CNT_W-1:0]  count_r;

  logic [NUM_SLOTS-1:0]  lowest;
  slot_t                 sel;
  logic                  last;
  logic                  is_status;

  // Isolate the lowest pending slot; slots drain in index order.
  assign lowest = en_r & (~en_r + NUM_SLOTS'(1));

  always_comb begin
    sel = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (lowest[i]) begin
        sel = slots_r[i];
      end
    end
  end

  assign last      = ((en_r & ~lowest) == '0);
  assign out_valid = |en_r;
  assign free      = !out_valid || (out_ready && last);
  assign is_status = (sel.op == OP_STATUS);

  assign out_bus_op    = sel.op;
  assign out_byte_val  = sel.byte_val;
  assign out_status    = is_status ? status_r : 2'b00;
  assign out_msg_count = is_status ? count_r : '0;
  assign out_last      = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= '0;
    end else if (load) begin
      en_r <= plan.en;
    end else if (out_valid && out_ready) begin
      en_r <= en_r & ~lowest;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots_r  <= plan.slots;
      status_r <= plan.status;
      count_r  <= plan.msg_count;
    end
  end

  `ASSERT_IMPLIES(a_load_when_free, load, free)
  `ASSERT_NEXT(a_no_new_slots, !load, ((en_r & ~$past(en_r)) == '0))
  `ASSERT_IMPLIES(a_status_is_last, out_valid && (sel.op == OP_STATUS), last)

endmodule

`default_nettype wire

// File: src/i2cms_plan.sv
// Combinational planner: the bus symbols and next state for one held request.
`default_nettype none

module i2cms_plan
  import i2cms_pkg::*;
#(
  parameter int unsigned MAX_MSGS = DEF_MAX_MSGS
) (
  input  wire req_t       item,
  input  wire seq_state_t state,
  output plan_t           plan,
  output seq_state_t      state_nxt
);

  localparam logic [MSG_CNT_W-1:0] MSG_CAP = msg_cap(MAX_MSGS);

  logic                 first;
  logic [7:0]           addr_wr;
  logic [7:0]           addr_rd;
  logic [MSG_CNT_W-1:0] cnt_closed;
  logic                 r1;
  logic                 r3;
  logic                 fail;
  logic [2:0]           p1;
  logic [2:0]           p2;

  assign first = !state.in_transfer;

  // 10-bit addressing sends the 11110xx prefix byte first, the low byte after it.
  always_comb begin
    if (item.ten_bit) begin
      addr_wr = ADDR10_PREFIX | (8'(item.dev_addr >> 7) & ADDR10_HI_MASK);
    end else begin
      addr_wr = {item.dev_addr[6:0], item.is_read};
    end
  end
  assign addr_rd = addr_wr | READ_BIT;

  assign cnt_closed = (state.msg_open && (state.msgs_done < MSG_CAP)) ?
                      state.msgs_done + MSG_CNT_W'(1) : state.msgs_done;

  always_comb begin
    plan      = '0;
    state_nxt = state;
    r1        = 1'b0;
    r3        = 1'b0;
    fail      = 1'b0;
    p1        = 3'd1;
    p2        = 3'd2;

    plan.slots[SL_HEAD].op       = OP_START;
    plan.slots[SL_BYTE].op       = OP_SEND;
    plan.slots[SL_AUX].op        = OP_STOP;
    plan.slots[SL_RTY1_START].op = OP_START;
    plan.slots[SL_RTY1_SEND].op  = OP_SEND;
    plan.slots[SL_ADDR_LO].op    = OP_SEND;
    plan.slots[SL_RESTART].op    = OP_RESTART;
    plan.slots[SL_ADDR_RD].op    = OP_SEND;
    plan.slots[SL_RTY2_STOP].op  = OP_STOP;
    plan.slots[SL_RTY2_START].op = OP_START;
    plan.slots[SL_RTY2_SEND].op  = OP_SEND;
    plan.slots[SL_STOP].op       = OP_STOP;
    plan.slots[SL_STATUS].op     = OP_STATUS;
    plan.status                  = ST_OK;

    unique case (item.req_type)
      REQ_HEADER: begin
        if (!state.aborted) begin
          state_nxt.in_transfer       = 1'b1;
          state_nxt.msgs_done         = first ? '0 : cnt_closed;
          state_nxt.cur_read          = item.is_read;
          state_nxt.cur_tolerate_nack = item.tolerate_nack;
          state_nxt.cur_no_master_ack = item.no_master_ack;
          state_nxt.msg_open          = 1'b1;

          plan.en[SL_HEAD]       = first || !item.skip_start;
          plan.slots[SL_HEAD].op = first ? OP_START : OP_RESTART;

          if (!item.skip_start) begin
            plan.en[SL_BYTE]                = 1'b1;
            plan.slots[SL_BYTE].byte_val    = addr_wr;
            // One retry of the first address byte: stop, start, resend.
            r1                              = !item.ack_bits[0] && !item.tolerate_nack;
            plan.en[SL_AUX]                 = r1;
            plan.en[SL_RTY1_START]          = r1;
            plan.en[SL_RTY1_SEND]           = r1;
            plan.slots[SL_RTY1_SEND].byte_val = addr_wr;
            p1   = r1 ? 3'd2 : 3'd1;
            fail = !(r1 ? item.ack_bits[1] : item.ack_bits[0]) && !item.tolerate_nack;

            if (item.ten_bit && !fail) begin
              plan.en[SL_ADDR_LO]             = 1'b1;
              plan.slots[SL_ADDR_LO].byte_val = item.dev_addr[7:0] & ADDR7_LO_MASK;
              fail = !item.ack_bits[p1] && !item.tolerate_nack;
              p2   = p1 + 3'd1;

              if (item.is_read && !fail) begin
                plan.en[SL_RESTART]               = 1'b1;
                plan.en[SL_ADDR_RD]               = 1'b1;
                plan.slots[SL_ADDR_RD].byte_val   = addr_rd;
                r3                                = !item.ack_bits[p2] && !item.tolerate_nack;
                plan.en[SL_RTY2_STOP]             = r3;
                plan.en[SL_RTY2_START]            = r3;
                plan.en[SL_RTY2_SEND]             = r3;
                plan.slots[SL_RTY2_SEND].byte_val = addr_rd;
                fail = !(r3 ? item.ack_bits[p2 + 3'd1] : item.ack_bits[p2]) &&
                       !item.tolerate_nack;
              end
            end

            if (fail) begin
              plan.en[SL_STOP]   = 1'b1;
              plan.en[SL_STATUS] = 1'b1;
              plan.status        = ST_ADDR_NACK;
              state_nxt.aborted  = 1'b1;
              state_nxt.msg_open = 1'b0;
            end
          end
        end
      end

      REQ_DATA: begin
        if (state.in_transfer && !state.aborted && state.msg_open) begin
          plan.en[SL_BYTE] = 1'b1;
          if (state.cur_read) begin
            plan.slots[SL_BYTE].op       = OP_RECV;
            plan.slots[SL_BYTE].byte_val = item.rd_byte;
            plan.en[SL_AUX]              = !state.cur_no_master_ack;
            plan.slots[SL_AUX].op        = item.last_byte ? OP_NACK : OP_ACK;
          end else begin
            plan.slots[SL_BYTE].byte_val = item.wr_byte;
            if (!item.ack_bits[0] && !state.cur_tolerate_nack) begin
              plan.en[SL_STOP]   = 1'b1;
              plan.en[SL_STATUS] = 1'b1;
              plan.status        = ST_DATA_NACK;
              state_nxt.aborted  = 1'b1;
              state_nxt.msg_open = 1'b0;
            end
          end
        end
      end

      REQ_END: begin
        if (state.in_transfer) begin
          if (!state.aborted) begin
            state_nxt.msgs_done = cnt_closed;
            plan.en[SL_STOP]    = 1'b1;
            plan.en[SL_STATUS]  = 1'b1;
          end
          state_nxt.in_transfer = 1'b0;
          state_nxt.aborted     = 1'b0;
          state_nxt.msg_open    = 1'b0;
        end
      end

      default: begin
        // Unused request code: no symbols, no state change.
      end
    endcase

    plan.msg_count = state_nxt.msgs_done;
  end

endmodule

`default_nettype wire

// File: src/i2c_master_transfer_sequencer_unit.sv
// I2C master transfer sequencer: turns request items into a stream of bus symbols.
// A request is registered in the hold register and loads into the result buffer once the
// buffer is free; the hold register can take a new request while the buffer drains.
// A request yields at most 13 symbols, handed out one per accepted transaction; a request
// yielding none leaves the result buffer empty.
// Reset (synchronous, rst_n low) clears the transfer state and empties both registers.
`default_nettype none
`include "assert_macros.svh"

module i2c_master_transfer_sequencer_unit
  import i2cms_pkg::*;
#(
  parameter int unsigned MAX_MSGS = DEF_MAX_MSGS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           in_req_type,
  input  wire logic [9:0]           in_dev_addr,
  input  wire logic                 in_ten_bit,
  input  wire logic                 in_is_read,
  input  wire logic                 in_tolerate_nack,
  input  wire logic                 in_skip_start,
  input  wire logic                 in_no_master_ack,
  input  wire logic [7:0]           in_wr_byte,
  input  wire logic [7:0]           in_rd_byte,
  input  wire logic [4:0]           in_ack_bits,
  input  wire logic                 in_last_byte,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [2:0]                out_bus_op,
  output logic [7:0]                out_byte_val,
  output logic [1:0]                out_status,
  output logic [MSG_CNT_W-1:0]      out_msg_count,
  output logic                      out_last
);

  localparam logic [MSG_CNT_W-1:0] MSG_CAP = msg_cap(MAX_MSGS);

  logic       hold_valid_r;
  req_t       hold_r;
  seq_state_t state_r;
  seq_state_t state_nxt;
  plan_t      plan;
  logic       buf_free;
  logic       xfer;

  assign xfer     = hold_valid_r && buf_free;
  assign in_ready = !hold_valid_r || buf_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid_r <= 1'b1;
    end else if (xfer) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_r.req_type      <= req_type_t'(in_req_type);
      hold_r.dev_addr      <= in_dev_addr;
      hold_r.ten_bit       <= in_ten_bit;
      hold_r.is_read       <= in_is_read;
      hold_r.tolerate_nack <= in_tolerate_nack;
      hold_r.skip_start    <= in_skip_start;
      hold_r.no_master_ack <= in_no_master_ack;
      hold_r.wr_byte       <= in_wr_byte;
      hold_r.rd_byte       <= in_rd_byte;
      hold_r.ack_bits      <= in_ack_bits;
      hold_r.last_byte     <= in_last_byte;
    end
  end

  // The transfer state advances when the held request moves into the result buffer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (xfer) begin
      state_r <= state_nxt;
    end
  end

  i2cms_plan #(
    .MAX_MSGS (MAX_MSGS)
  ) u_plan (
    .item      (hold_r),
    .state     (state_r),
    .plan      (plan),
    .state_nxt (state_nxt)
  );

  i2cms_out_buf u_out_buf (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (xfer),
    .plan          (plan),
    .free          (buf_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_bus_op    (out_bus_op),
    .out_byte_val  (out_byte_val),
    .out_status    (out_status),
    .out_msg_count (out_msg_count),
    .out_last      (out_last)
  );

  `ASSERT_IMPLIES(a_abort_in_transfer, state_r.aborted, state_r.in_transfer)
  `ASSERT_ALWAYS(a_count_cap, state_r.msgs_done <= MSG_CAP)
  `ASSERT_NEXT(a_hold_kept, hold_valid_r && !xfer, hold_valid_r && $stable(hold_r))

endmodule

`default_nettype wire

// File: sim/i2c_master_transfer_sequencer_unit_test.sv
// Self-checking testbench for the I2C master transfer sequencer, with bus-symbol prediction.
`default_nettype none

import i2cms_pkg::*;

typedef struct packed {
  logic [2:0]           op;
  logic [7:0]           byte_val;
  logic [1:0]           status;
  logic [MSG_CNT_W-1:0] msg_count;
  logic                 last;
} bus_symbol_t;

class bus_symbol_tracker;
  bit                   in_transfer;
  bit                   aborted;
  bit                   msg_open;
  bit                   cur_read;
  bit                   cur_tolerate_nack;
  bit                   cur_no_master_ack;
  logic [MSG_CNT_W-1:0] msgs_done;
  int unsigned          count_cap;
  logic [4:0]           ack_word;
  int unsigned          ack_pos;
  bus_symbol_t          step_symbols[$];
  bus_symbol_t          awaited_symbols[$];
  int unsigned          mismatches;

  function new(int unsigned max_msgs);
    count_cap = (max_msgs > 255) ? 255 : max_msgs;
    in_transfer = 0;
    aborted = 0;
    msg_open = 0;
    cur_read = 0;
    cur_tolerate_nack = 0;
    cur_no_master_ack = 0;
    msgs_done = '0;
    mismatches = 0;
  endfunction

  function void put_symbol(bus_op_t op, logic [7:0] val = 8'h00, status_t st = ST_OK,
                           logic [MSG_CNT_W-1:0] cnt = '0);
    bus_symbol_t s;
    s.op = op;
    s.byte_val = val;
    s.status = st;
    s.msg_count = cnt;
    s.last = 1'b0;
    step_symbols.push_back(s);
  endfunction

  // Slave acknowledges are consumed in order; bytes beyond the fifth see a NACK.
  function bit take_ack();
    bit acked;
    acked = (ack_pos < 5) ? ack_word[ack_pos] : 1'b0;
    ack_pos++;
    return acked;
  endfunction

  function void close_message();
    if (msg_open && msgs_done < count_cap) msgs_done++;
    msg_open = 0;
  endfunction

  function void abort_with(status_t code);
    put_symbol(OP_STOP);
    put_symbol(OP_STATUS, 8'h00, code, msgs_done);
    aborted = 1;
    msg_open = 0;
  endfunction

  // One address byte, repeated once after stop and start when a retry is allowed.
  function bit address_phase(logic [7:0] addr_byte, bit retry);
    bit acked;
    put_symbol(OP_SEND, addr_byte);
    acked = take_ack();
    if (!acked && retry) begin
      put_symbol(OP_STOP);
      put_symbol(OP_START);
      put_symbol(OP_SEND, addr_byte);
      acked = take_ack();
    end
    return acked;
  endfunction

  function void take_request(req_t r);
    bit         is_first;
    bit         alive;
    bit         retry;
    logic [7:0] addr_byte;
    step_symbols.delete();
    ack_word = r.ack_bits;
    ack_pos = 0;
    case (r.req_type)
      REQ_HEADER: begin
        if (!aborted) begin
          is_first = !in_transfer;
          if (is_first) begin
            put_symbol(OP_START);
            in_transfer = 1;
            msgs_done = '0;
            msg_open = 0;
          end else begin
            close_message();
          end
          cur_read = r.is_read;
          cur_tolerate_nack = r.tolerate_nack;
          cur_no_master_ack = r.no_master_ack;
          msg_open = 1;
          if (!r.skip_start) begin
            if (!is_first) put_symbol(OP_RESTART);
            retry = !r.tolerate_nack;
            if (r.ten_bit) begin
              addr_byte = ADDR10_PREFIX | {5'b00000, r.dev_addr[9:8], 1'b0};
              alive = address_phase(addr_byte, retry) || r.tolerate_nack;
              if (alive) begin
                put_symbol(OP_SEND, r.dev_addr[7:0]);
                alive = take_ack() || r.tolerate_nack;
              end
              // A 10-bit read turns the bus around with a restart and the read prefix.
              if (alive && r.is_read) begin
                put_symbol(OP_RESTART);
                alive = address_phase(addr_byte | READ_BIT, retry) || r.tolerate_nack;
              end
            end else begin
              addr_byte = {r.dev_addr[6:0], r.is_read};
              alive = address_phase(addr_byte, retry) || r.tolerate_nack;
            end
            if (!alive) abort_with(ST_ADDR_NACK);
          end
        end
      end
      REQ_DATA: begin
        if (in_transfer && !aborted && msg_open) begin
          if (cur_read) begin
            put_symbol(OP_RECV, r.rd_byte);
            if (!cur_no_master_ack) begin
              if (r.last_byte) put_symbol(OP_NACK);
              else put_symbol(OP_ACK);
            end
          end else begin
            put_symbol(OP_SEND, r.wr_byte);
            if (!take_ack() && !cur_tolerate_nack) abort_with(ST_DATA_NACK);
          end
        end
      end
      REQ_END: begin
        if (in_transfer) begin
          if (!aborted) begin
            close_message();
            put_symbol(OP_STOP);
            put_symbol(OP_STATUS, 8'h00, ST_OK, msgs_done);
          end
          in_transfer = 0;
          aborted = 0;
          msg_open = 0;
        end
      end
      default: ;
    endcase
    if (step_symbols.size() > 0) step_symbols[step_symbols.size() - 1].last = 1'b1;
    foreach (step_symbols[i]) awaited_symbols.push_back(step_symbols[i]);
  endfunction

  function void check_symbol(bus_symbol_t got);
    bus_symbol_t want;
    if (awaited_symbols.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected bus symbol: op=%0d byte=%02h status=%0d count=%0d last=%0b",
                 got.op, got.byte_val, got.status, got.msg_count, got.last);
      return;
    end
    want = awaited_symbols.pop_front();
    if (got.op !== want.op || got.byte_val !== want.byte_val || got.status !== want.status ||
        got.msg_count !== want.msg_count || got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("bus symbol mismatch: expected op=%0d byte=%02h status=%0d count=%0d last=%0b",
                 want.op, want.byte_val, want.status, want.msg_count, want.last);
        $display("                     got      op=%0d byte=%02h status=%0d count=%0d last=%0b",
                 got.op, got.byte_val, got.status, got.msg_count, got.last);
      end
    end
  endfunction

  function int unsigned pending();
    return awaited_symbols.size();
  endfunction
endclass

module i2c_master_transfer_sequencer_unit_test;

  localparam int unsigned MSG_LIMIT    = DEF_MAX_MSGS;
  localparam int unsigned RANDOM_ITEMS = 125;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_req_type = 2'd0;
  logic [9:0]           in_dev_addr = '0;
  logic                 in_ten_bit = 1'b0;
  logic                 in_is_read = 1'b0;
  logic                 in_tolerate_nack = 1'b0;
  logic                 in_skip_start = 1'b0;
  logic                 in_no_master_ack = 1'b0;
  logic [7:0]           in_wr_byte = '0;
  logic [7:0]           in_rd_byte = '0;
  logic [4:0]           in_ack_bits = '0;
  logic                 in_last_byte = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [2:0]           out_bus_op;
  logic [7:0]           out_byte_val;
  logic [1:0]           out_status;
  logic [MSG_CNT_W-1:0] out_msg_count;
  logic                 out_last;

  int unsigned send_idle_pct = 33;
  int unsigned recv_idle_pct = 76;
  int unsigned items_sent = 0;

  bus_symbol_tracker tracker = new(MSG_LIMIT);

  i2c_master_transfer_sequencer_unit #(
    .MAX_MSGS(MSG_LIMIT)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req_type(in_req_type),
    .in_dev_addr(in_dev_addr),
    .in_ten_bit(in_ten_bit),
    .in_is_read(in_is_read),
    .in_tolerate_nack(in_tolerate_nack),
    .in_skip_start(in_skip_start),
    .in_no_master_ack(in_no_master_ack),
    .in_wr_byte(in_wr_byte),
    .in_rd_byte(in_rd_byte),
    .in_ack_bits(in_ack_bits),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_bus_op(out_bus_op),
    .out_byte_val(out_byte_val),
    .out_status(out_status),
    .out_msg_count(out_msg_count),
    .out_last(out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_symbol({out_bus_op, out_byte_val, out_status, out_msg_count, out_last});
  end

  // Called just after a falling edge; returns just after the falling edge that
  // follows the transaction, leaving valid high for the next caller to decide.
  task automatic push_request(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_req_type      <= r.req_type;
    in_dev_addr      <= r.dev_addr;
    in_ten_bit       <= r.ten_bit;
    in_is_read       <= r.is_read;
    in_tolerate_nack <= r.tolerate_nack;
    in_skip_start    <= r.skip_start;
    in_no_master_ack <= r.no_master_ack;
    in_wr_byte       <= r.wr_byte;
    in_rd_byte       <= r.rd_byte;
    in_ack_bits      <= r.ack_bits;
    in_last_byte     <= r.last_byte;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_request(r);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic [4:0] mostly_ack();
    logic [4:0] bits;
    for (int i = 0; i < 5; i++) bits[i] = ($urandom_range(99) < 85);
    return bits;
  endfunction

  function automatic req_t random_request(req_type_t kind);
    req_t r;
    r.req_type      = kind;
    r.dev_addr      = 10'($urandom);
    r.ten_bit       = 1'($urandom);
    r.is_read       = 1'($urandom);
    r.tolerate_nack = 1'($urandom);
    r.skip_start    = 1'($urandom);
    r.no_master_ack = 1'($urandom);
    r.wr_byte       = 8'($urandom);
    r.rd_byte       = 8'($urandom);
    r.ack_bits      = 5'($urandom);
    r.last_byte     = 1'($urandom);
    return r;
  endfunction

  function automatic req_t make_request(req_type_t kind, logic [9:0] dev, bit ten, bit rd,
                                        bit ign, bit skip, bit nma, logic [7:0] wr,
                                        logic [7:0] rdb, logic [4:0] acks, bit lastb);
    req_t r;
    r = '{req_type: kind, dev_addr: dev, ten_bit: ten, is_read: rd, tolerate_nack: ign,
          skip_start: skip, no_master_ack: nma, wr_byte: wr, rd_byte: rdb,
          ack_bits: acks, last_byte: lastb};
    return r;
  endfunction

  task automatic run_random_transfer();
    int unsigned n_msgs;
    int unsigned n_slots;
    req_t        r;
    n_msgs = ($urandom_range(9) == 0) ? $urandom_range(8, 5) : $urandom_range(3, 1);
    for (int m = 0; m < n_msgs; m++) begin
      r = random_request(REQ_HEADER);
      r.tolerate_nack = ($urandom_range(3) == 0);
      r.skip_start    = ($urandom_range(6) == 0);
      r.no_master_ack = ($urandom_range(4) == 0);
      r.ack_bits      = mostly_ack();
      push_request(r);
      n_slots = $urandom_range(4);
      for (int k = 0; k < n_slots; k++) begin
        r = random_request(REQ_DATA);
        r.ack_bits  = mostly_ack();
        r.last_byte = (k == n_slots - 1) ^ ($urandom_range(9) == 0);
        push_request(r);
        // Occasional noise: any kind of item with unconstrained content.
        if ($urandom_range(19) == 0) push_request(random_request(req_type_t'($urandom_range(2))));
      end
    end
    if ($urandom_range(19) != 0) push_request(random_request(REQ_END));
  endtask

  initial begin
    int unsigned base;
    req_t        r;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // 7-bit write, 10-bit read, skipped restart with no master ACK, extra bytes.
    push_request(make_request(REQ_HEADER, 10'h3FF, 0, 0, 0, 0, 0, 8'h00, 8'h00, 5'h1F, 0));
    push_request(make_request(REQ_DATA,   10'h000, 0, 0, 0, 0, 0, 8'hFF, 8'h00, 5'h01, 0));
    push_request(make_request(REQ_DATA,   10'h000, 0, 0, 0, 0, 0, 8'h00, 8'hFF, 5'h01, 1));
    push_request(make_request(REQ_DATA,   10'h000, 0, 0, 0, 0, 0, 8'h5A, 8'h00, 5'h1F, 0));
    push_request(make_request(REQ_HEADER, 10'h3FF, 1, 1, 0, 0, 0, 8'h00, 8'h00, 5'h1F, 0));
    push_request(make_request(REQ_DATA,   10'h000, 0, 0, 0, 0, 0, 8'h00, 8'hFF, 5'h00, 0));
    push_request(make_request(REQ_DATA,   10'h000, 0, 0, 0, 0, 0, 8'hFF, 8'h00, 5'h00, 1));
    push_request(make_request(REQ_HEADER, 10'h000, 0, 1, 0, 1, 1, 8'h00, 8'h00, 5'h00, 0));
    push_request(make_request(REQ_DATA,   10'h000, 0, 0, 0, 0, 0, 8'h00, 8'hA5, 5'h00, 1));
    push_request(make_request(REQ_END,    10'h000, 0, 0, 0, 0, 0, 8'h00, 8'h00, 5'h00, 0));
    // Data slot and end of transfer while idle.
    push_request(make_request(REQ_DATA,   10'h3FF, 1, 1, 1, 1, 1, 8'hFF, 8'hFF, 5'h1F, 1));
    push_request(make_request(REQ_END,    10'h3FF, 1, 1, 1, 1, 1, 8'hFF, 8'hFF, 5'h1F, 1));
    // Address retry that succeeds, then a retry that fails and aborts the transfer.
    push_request(make_request(REQ_HEADER, 10'h000, 1, 0, 0, 0, 0, 8'h00, 8'h00, 5'b00110, 0));
    push_request(make_request(REQ_HEADER, 10'h000, 0, 1, 0, 0, 0, 8'h00, 8'h00, 5'b00000, 0));
    push_request(make_request(REQ_DATA,   10'h000, 0, 0, 0, 0, 0, 8'h11, 8'h22, 5'h1F, 0));
    push_request(make_request(REQ_HEADER, 10'h155, 0, 0, 0, 0, 0, 8'h00, 8'h00, 5'h1F, 0));
    push_request(make_request(REQ_END,    10'h000, 0, 0, 0, 0, 0, 8'h00, 8'h00, 5'h00, 0));
    // Ignored NACKs on a 10-bit read, then a data NACK abort.
    push_request(make_request(REQ_HEADER, 10'h2AA, 1, 1, 1, 0, 0, 8'h00, 8'h00, 5'b00000, 0));
    push_request(make_request(REQ_DATA,   10'h000, 0, 0, 0, 0, 0, 8'h00, 8'h3C, 5'h00, 1));
    push_request(make_request(REQ_HEADER, 10'h055, 0, 0, 0, 0, 0, 8'h00, 8'h00, 5'b00001, 0));
    push_request(make_request(REQ_DATA,   10'h000, 0, 0, 0, 0, 0, 8'h81, 8'h00, 5'b11110, 0));
    push_request(make_request(REQ_END,    10'h000, 0, 0, 0, 0, 0, 8'h00, 8'h00, 5'h00, 0));
    // Longest header: 10-bit read after a skipped start; the write and read prefix bytes
    // both need their retry, and the second retry fails.
    push_request(make_request(REQ_HEADER, 10'h155, 0, 0, 0, 1, 0, 8'h00, 8'h00, 5'h00, 0));
    push_request(make_request(REQ_HEADER, 10'h3FF, 1, 1, 0, 0, 0, 8'h00, 8'h00, 5'b00110, 0));
    push_request(make_request(REQ_END,    10'h000, 0, 0, 0, 0, 0, 8'h00, 8'h00, 5'h00, 0));

    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      case ((items_sent - base) * 3 / RANDOM_ITEMS)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 76;
        end
        1: begin
          send_idle_pct = 76;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      run_random_transfer();
    end

    // Close the open transfer if any, then run one long transfer so that the
    // message counter saturates.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_request(random_request(REQ_END));
    for (int i = 0; i < 258; i++) begin
      r = random_request(REQ_HEADER);
      r.tolerate_nack = 1'b1;
      r.skip_start    = ($urandom_range(9) != 0);
      push_request(r);
    end
    push_request(random_request(REQ_END));
    in_valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
